// ----- rtl/wia_pkg.sv -----
// Shared types and constants for the 512-bit wide integer ALU.
package wia_pkg;

   localparam int LIMB_W    = 64;
   localparam int HALF_W    = 32;
   localparam int INDEX_W   = 3;
   localparam int NUM_LIMBS = 8;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_XOR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      S_LOAD  = 3'd0,
      S_RD    = 3'd1,
      S_EX    = 3'd2,
      S_OUT   = 3'd3,
      S_MRD   = 3'd4,
      S_MPP   = 3'd5,
      S_MFIN  = 3'd6,
      S_MEMIT = 3'd7
   } state_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic     clear;       // start of a run: clear carry and accumulator
      logic     ex_en;       // add, subtract or xor one limb
      logic     first_limb;  // limb zero is being worked on
      logic     mul_en;      // issue one 32x32 partial product
      logic [1:0] mul_q;     // which half pair the partial product uses
      logic     emit_mul;    // take one column out of the accumulator
      func_type op;
   } ctrl_type;

endpackage

// ----- rtl/wia_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/wia_datapath.sv -----
// Limb datapath: carry chain adder, shared 32x32 multiplier and column accumulator.
module wia_datapath #(
   parameter int NUM_LIMBS = wia_pkg::NUM_LIMBS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wia_pkg::ctrl_type          ctrl,
   input  logic [wia_pkg::LIMB_W-1:0] a_data,
   input  logic [wia_pkg::LIMB_W-1:0] b_data,
   output logic [wia_pkg::LIMB_W-1:0] result_limb
);

   localparam int LW    = wia_pkg::LIMB_W;
   localparam int HW    = wia_pkg::HALF_W;
   // column sum of up to NUM_LIMBS full products plus carried columns
   localparam int ACC_W = 2 * LW + $clog2(NUM_LIMBS) + 1;

   logic           carry_ff, carry_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [LW-1:0]  mul_ff, mul_in;
   logic [1:0]     msh_ff, msh_in;
   logic           mpend_ff, mpend_in;
   logic [LW-1:0]  out_ff, out_in;

   logic [LW:0]    sum_w;
   logic [LW:0]    diff_w;
   logic [HW-1:0]  mul_x, mul_y;
   logic [ACC_W-1:0] addend;

   always_comb begin
      sum_w  = {1'b0, a_data} + {1'b0, b_data} + {{LW{1'b0}}, carry_ff};
      diff_w = {1'b0, a_data} - {1'b0, b_data} - {{LW{1'b0}}, carry_ff};

      // select half limbs and weight of this partial product
      mul_x  = ctrl.mul_q[1] ? a_data[LW-1:HW] : a_data[HW-1:0];
      mul_y  = ctrl.mul_q[0] ? b_data[LW-1:HW] : b_data[HW-1:0];
      addend = ACC_W'(mul_ff) << {msh_ff, 5'd0};

      carry_in = carry_ff;
      out_in   = out_ff;
      acc_in   = acc_ff;
      mul_in   = mul_ff;
      msh_in   = msh_ff;
      mpend_in = 1'b0;

      // one limb of add, subtract or xor
      if (ctrl.ex_en) begin
         case (ctrl.op)
            wia_pkg::FUNC_ADD: begin
               out_in   = sum_w[LW-1:0];
               carry_in = sum_w[LW];
            end
            wia_pkg::FUNC_SUB: begin
               out_in   = diff_w[LW-1:0];
               carry_in = diff_w[LW];
            end
            wia_pkg::FUNC_XOR: begin
               out_in = ctrl.first_limb ? (a_data ^ b_data) : a_data;
            end
            default: begin
               out_in = out_ff;
            end
         endcase
      end

      // multiply into a register, then add to the accumulator in the next cycle
      if (ctrl.mul_en) begin
         mul_in   = mul_x * mul_y;
         msh_in   = {ctrl.mul_q[1] & ctrl.mul_q[0], ctrl.mul_q[1] ^ ctrl.mul_q[0]};
         mpend_in = 1'b1;
      end

      if (ctrl.clear) begin
         carry_in = 1'b0;
         acc_in   = '0;
      end else if (mpend_ff) begin
         acc_in = acc_ff + addend;
      end else if (ctrl.emit_mul) begin
         out_in = acc_ff[LW-1:0];
         acc_in = acc_ff >> LW;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mpend_ff <= 1'b0;
      end else begin
         mpend_ff <= mpend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      acc_ff   <= acc_in;
      mul_ff   <= mul_in;
      msh_ff   <= msh_in;
      out_ff   <= out_in;
   end

   assign result_limb = out_ff;

   // A column is never read out while a partial product is still being added
   a_emit_after_add: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit_mul |-> !mpend_ff)
      else $error("column emitted with a partial product pending");

   // Every issued partial product is added in the next cycle
   a_mul_accumulates: assert property (@(posedge clock) disable iff (reset)
      ctrl.mul_en && !ctrl.clear |=> mpend_ff)
      else $error("partial product not accumulated");

endmodule

// ----- rtl/wia_ctrl.sv -----
// Sequencer: limb loading, per-limb add/sub/xor steps and product-scanning multiply order.
module wia_ctrl #(
   parameter int NUM_LIMBS = wia_pkg::NUM_LIMBS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_func,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [wia_pkg::INDEX_W-1:0]  rsp_result_index,
   output logic                         rsp_result_last,
   output logic                         wr_en,
   output logic [$clog2(NUM_LIMBS)-1:0] wr_addr,
   output logic                         rd_en,
   output logic [$clog2(NUM_LIMBS)-1:0] a_rd_addr,
   output logic [$clog2(NUM_LIMBS)-1:0] b_rd_addr,
   output wia_pkg::ctrl_type            ctrl
);

   localparam int CW = $clog2(NUM_LIMBS);
   localparam logic [CW-1:0] LAST = CW'(NUM_LIMBS - 1);

   wia_pkg::state_type state_ff, state_in;
   wia_pkg::func_type  func_ff, func_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] l_ff, l_in;
   logic [1:0]    q_ff, q_in;
   logic          req_take, rsp_take;
   logic [CW+2:0] idx_ext;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Next state and outputs
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      cnt_in   = cnt_ff;
      l_in     = l_ff;
      q_in     = q_ff;

      ctrl            = '0;
      ctrl.op         = func_ff;
      ctrl.first_limb = (cnt_ff == '0);
      ctrl.mul_q      = q_ff;

      rd_en     = 1'b0;
      a_rd_addr = cnt_ff;
      b_rd_addr = (func_ff == wia_pkg::FUNC_XOR) ? '0 : cnt_ff;

      case (state_ff)
         wia_pkg::S_LOAD: begin
            if (req_take) begin
               if (cnt_ff == LAST) begin
                  func_in    = wia_pkg::func_type'(req_func);
                  cnt_in     = '0;
                  l_in       = '0;
                  ctrl.clear = 1'b1;
                  state_in   = (req_func == wia_pkg::FUNC_MUL) ? wia_pkg::S_MRD
                                                               : wia_pkg::S_RD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         wia_pkg::S_RD: begin
            rd_en    = 1'b1;
            state_in = wia_pkg::S_EX;
         end
         wia_pkg::S_EX: begin
            ctrl.ex_en = 1'b1;
            state_in   = wia_pkg::S_OUT;
         end
         wia_pkg::S_OUT: begin
            if (rsp_take) begin
               l_in = '0;
               if (cnt_ff == LAST) begin
                  cnt_in   = '0;
                  state_in = wia_pkg::S_LOAD;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = (func_ff == wia_pkg::FUNC_MUL) ? wia_pkg::S_MRD
                                                             : wia_pkg::S_RD;
               end
            end
         end
         wia_pkg::S_MRD: begin
            // fetch a[l] and b[k-l] for the current column k
            rd_en     = 1'b1;
            a_rd_addr = l_ff;
            b_rd_addr = cnt_ff - l_ff;
            q_in      = '0;
            state_in  = wia_pkg::S_MPP;
         end
         wia_pkg::S_MPP: begin
            ctrl.mul_en = 1'b1;
            if (q_ff == 2'd3) begin
               if (l_ff == cnt_ff) begin
                  state_in = wia_pkg::S_MFIN;
               end else begin
                  l_in     = l_ff + 1'b1;
                  state_in = wia_pkg::S_MRD;
               end
            end else begin
               q_in = q_ff + 1'b1;
            end
         end
         wia_pkg::S_MFIN: begin
            state_in = wia_pkg::S_MEMIT;
         end
         wia_pkg::S_MEMIT: begin
            ctrl.emit_mul = 1'b1;
            state_in      = wia_pkg::S_OUT;
         end
         default: begin
            state_in = wia_pkg::S_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wia_pkg::S_LOAD;
         cnt_ff   <= '0;
         l_ff     <= '0;
         q_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         l_ff     <= l_in;
         q_ff     <= q_in;
      end
   end

   // Held operation code
   always_ff @(posedge clock) begin
      func_ff <= func_in;
   end

   assign req_stall = (state_ff != wia_pkg::S_LOAD);
   assign rsp_valid = (state_ff == wia_pkg::S_OUT);
   assign wr_en     = req_take;
   assign wr_addr   = cnt_ff;

   // Index wraps modulo eight on wide configurations
   assign idx_ext          = {3'b000, cnt_ff};
   assign rsp_result_index = idx_ext[wia_pkg::INDEX_W-1:0];
   assign rsp_result_last  = (cnt_ff == LAST);

   // Final limb of an operand starts a run at limb zero
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      req_take && cnt_ff == LAST |=> cnt_ff == '0 && req_stall)
      else $error("run did not start after the final operand word");

   // Partial product index stays inside the current column
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wia_pkg::S_MRD || state_ff == wia_pkg::S_MPP) |-> l_ff <= cnt_ff)
      else $error("partial product index outside column");

   // Last result word hands the block back to loading
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_result_last |=> !req_stall && cnt_ff == '0)
      else $error("block not ready after the last result word");

endmodule

// ----- rtl/wide_int_alu_512.sv -----
// Top level of the multi-limb wide integer ALU (add, subtract, multiply, xor low limb).
//
// Usage:
//   The req channel takes one word per cycle while req_stall is low: one
//   limb of operand A and one of operand B, least significant first. On the
//   NUM_LIMBS-th word req_func picks the operation (add, subtract, multiply
//   truncated to the operand width, or xor of the low limbs). Earlier words
//   ignore req_func and give no result. The rsp channel then returns NUM_LIMBS
//   words, low limb first, with rsp_result_index (modulo eight) and rsp_result_last
//   on the top limb. Carry or borrow out of the top limb is dropped.
// Sequence:
//   Loading takes NUM_LIMBS words. Add, subtract and xor read, execute and
//   present each result word in turn. Multiply runs product scanning on one
//   shared 32x32 multiplier: each limb pair is read and its four half products
//   issued, NUM_LIMBS*(NUM_LIMBS+1)/2 pairs, then each column finishes, is
//   emitted and presented. req_stall stays high from the final operand word
//   until the last result word is taken.
// Reset and stalls:
//   Reset returns the sequencer to loading at limb zero. While rsp_stall is high
//   the current result word holds and the sequencer waits.
module wide_int_alu_512 #(
   parameter int NUM_LIMBS = wia_pkg::NUM_LIMBS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [wia_pkg::LIMB_W-1:0]  req_a_limb,
   input  logic [wia_pkg::LIMB_W-1:0]  req_b_limb,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [wia_pkg::LIMB_W-1:0]  rsp_result_limb,
   output logic [wia_pkg::INDEX_W-1:0] rsp_result_index,
   output logic                        rsp_result_last
);

   localparam int CW = $clog2(NUM_LIMBS);

   wia_pkg::ctrl_type          ctrl;
   logic                       wr_en, rd_en;
   logic [CW-1:0]              wr_addr, a_rd_addr, b_rd_addr;
   logic [wia_pkg::LIMB_W-1:0] a_data, b_data;

   wia_ctrl #(
      .NUM_LIMBS(NUM_LIMBS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_index(rsp_result_index),
      .rsp_result_last (rsp_result_last),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .rd_en           (rd_en),
      .a_rd_addr       (a_rd_addr),
      .b_rd_addr       (b_rd_addr),
      .ctrl            (ctrl)
   );

   // Operand A limb store
   wia_ram #(
      .WIDTH(wia_pkg::LIMB_W),
      .DEPTH(NUM_LIMBS)
   ) u_a_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_a_limb),
      .rd_en  (rd_en),
      .rd_addr(a_rd_addr),
      .rd_data(a_data)
   );

   // Operand B limb store
   wia_ram #(
      .WIDTH(wia_pkg::LIMB_W),
      .DEPTH(NUM_LIMBS)
   ) u_b_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_b_limb),
      .rd_en  (rd_en),
      .rd_addr(b_rd_addr),
      .rd_data(b_data)
   );

   wia_datapath #(
      .NUM_LIMBS(NUM_LIMBS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .a_data     (a_data),
      .b_data     (b_data),
      .result_limb(rsp_result_limb)
   );

endmodule
